// ===== hw/rtl/stok_pkg.sv =====
// Shared types, character constants and tokenizer step logic.
`timescale 1ns / 1ps
package stok_pkg;

	localparam int CHAR_W  = 16;
	localparam int KIND_W  = 2;
	localparam int MAX_RES = 5;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_WORD  = 3'd1;
	localparam logic [2:0] MODE_QUOTE = 3'd2;
	localparam logic [2:0] MODE_BLOCK = 3'd3;
	localparam logic [2:0] MODE_LINE  = 3'd4;

	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

	localparam logic [CHAR_W-1:0] CH_LPAREN = 16'h0028;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 16'h0029;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 16'h007B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 16'h007D;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 16'h002C;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_CR     = 16'h000D;
	localparam logic [CHAR_W-1:0] CH_LF     = 16'h000A;
	localparam logic [CHAR_W-1:0] CH_TAB    = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 16'h0022;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 16'h002F;
	localparam logic [CHAR_W-1:0] CH_STAR   = 16'h002A;

	typedef struct packed {
		logic [2:0] mode;
		logic       pending_slash;
		logic       star_seen;
		logic       token_open;
	} tok_state_t;

	typedef struct packed {
		logic [CNT_W-1:0]                 cnt;
		logic [MAX_RES-1:0][KIND_W-1:0]   kind;
		logic [MAX_RES-1:0][CHAR_W-1:0]   ch;
	} bundle_t;

	typedef struct packed {
		tok_state_t st;
		bundle_t    b;
	} step_t;

	localparam tok_state_t STATE_RESET = '{mode: MODE_IDLE, pending_slash: 1'b0,
		star_seen: 1'b0, token_open: 1'b0};

	function automatic logic is_blank(logic [CHAR_W-1:0] c);
		return c inside {CH_SPACE, CH_CR, CH_LF, CH_TAB};
	endfunction

	function automatic logic is_solo(logic [CHAR_W-1:0] c);
		return c inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA};
	endfunction

	function automatic step_t emit(step_t r, logic [KIND_W-1:0] k, logic [CHAR_W-1:0] c);
		step_t o;
		o = r;
		if (r.b.cnt < CNT_W'(MAX_RES)) begin
			o.b.kind[r.b.cnt] = k;
			o.b.ch[r.b.cnt]   = c;
			o.b.cnt           = r.b.cnt + 1'b1;
		end
		return o;
	endfunction

	function automatic step_t close_token(step_t r);
		step_t o;
		o = r;
		if (r.st.token_open)
			o = emit(o, KIND_END, '0);
		o.st.token_open = 1'b0;
		return o;
	endfunction

	function automatic step_t word_char(step_t r, logic [CHAR_W-1:0] c);
		step_t o;
		o = r;
		if (is_blank(c)) begin
			o = close_token(o);
			o.st.mode = MODE_IDLE;
		end else if (is_solo(c)) begin
			o = close_token(o);
			o = emit(o, KIND_CHAR, c);
			o = emit(o, KIND_END, '0);
			o.st.mode = MODE_IDLE;
		end else if (c == CH_SLASH) begin
			o.st.pending_slash = 1'b1;
		end else begin
			o = emit(o, KIND_CHAR, c);
			o.st.token_open = 1'b1;
		end
		return o;
	endfunction

	function automatic step_t tok_step(tok_state_t s, logic [CHAR_W-1:0] c, logic eos);
		step_t r;
		r.st = s;
		r.b  = '0;
		case (s.mode)
			MODE_WORD: begin
				if (s.pending_slash) begin
					r.st.pending_slash = 1'b0;
					if (c == CH_STAR) begin
						r = close_token(r);
						r.st.mode      = MODE_BLOCK;
						r.st.star_seen = 1'b1;
					end else if (c == CH_SLASH) begin
						r = close_token(r);
						r.st.mode = MODE_LINE;
					end else begin
						r = emit(r, KIND_CHAR, CH_SLASH);
						r.st.token_open = 1'b1;
						r = word_char(r, c);
					end
				end else begin
					r = word_char(r, c);
				end
			end
			MODE_QUOTE: begin
				if (c == CH_QUOTE) begin
					r = close_token(r);
					r.st.mode = MODE_IDLE;
				end else begin
					r = emit(r, KIND_CHAR, c);
					r.st.token_open = 1'b1;
				end
			end
			MODE_BLOCK: begin
				if (s.star_seen && c == CH_SLASH) begin
					r.st.star_seen = 1'b0;
					r.st.mode      = MODE_IDLE;
				end else begin
					r.st.star_seen = (c == CH_STAR);
				end
			end
			MODE_LINE: begin
				if (c == CH_CR || c == CH_LF)
					r.st.mode = MODE_IDLE;
			end
			default: begin
				r.st = STATE_RESET;
				if (!is_blank(c)) begin
					if (is_solo(c)) begin
						r = emit(r, KIND_CHAR, c);
						r = emit(r, KIND_END, '0);
					end else if (c == CH_QUOTE) begin
						r.st.mode = MODE_QUOTE;
					end else begin
						r.st.mode = MODE_WORD;
						r = word_char(r, c);
					end
				end
			end
		endcase
		if (eos) begin
			if (r.st.pending_slash) begin
				r = emit(r, KIND_CHAR, CH_SLASH);
				r.st.token_open    = 1'b1;
				r.st.pending_slash = 1'b0;
			end
			r = close_token(r);
			r = emit(r, KIND_DONE, '0);
			r.st = STATE_RESET;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/stok_front.sv =====
// Front end: accepts characters, tracks tokenizer state, builds result bundles.
`timescale 1ns / 1ps
module stok_front import stok_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              end_of_script,
	input  logic              q_full,
	output logic              in_stall,
	output logic              push,
	output bundle_t           push_data
);

	tok_state_t state_q;
	step_t      nxt;
	logic       accept;

	assign nxt       = tok_step(state_q, char_code, end_of_script);
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign push      = accept && (nxt.b.cnt != '0);
	assign push_data = nxt.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= nxt.st;
		end
	end

endmodule

// ===== hw/rtl/stok_queue.sv =====
// Short bundle queue between front and back end.
`timescale 1ns / 1ps
module stok_queue import stok_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output logic    full,
	output logic    not_empty,
	output bundle_t head
);

	bundle_t             mem_q [Q_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == QCNT_W'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/stok_back.sv =====
// Back end: walks each bundle and drives one result per transaction.
`timescale 1ns / 1ps
module stok_back import stok_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  bundle_t            head,
	output logic               pop,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [KIND_W-1:0]  kind,
	output logic [CHAR_W-1:0]  token_char,
	output logic               last_in_run
);

	logic [CNT_W-1:0]  idx_q;
	logic              valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              load;
	logic              is_last;

	assign load    = not_empty && (!valid_q || !out_stall);
	assign is_last = (idx_q == head.cnt - 1'b1);
	assign pop     = load && is_last;

	assign out_valid   = valid_q;
	assign kind        = kind_q;
	assign token_char  = char_q;
	assign last_in_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
			if (load)
				idx_q <= is_last ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= head.kind[idx_q];
			char_q <= head.ch[idx_q];
			last_q <= is_last;
		end
	end

endmodule

// ===== hw/rtl/script_tokenizer_with_comments.sv =====
// Top level of the script tokenizer with comment skipping.
//
// Input channel: in_valid / in_stall carry one 16-bit character (char_code)
// and end_of_script per transaction. Output channel: out_valid / out_stall
// carry one result per transaction: kind (token char, end of token, end of
// script), token_char, and last_in_run on the final result of a character.
// A character may cause zero to five results.
//
// The first result of a character is registered: the bundle queue is written at the
// edge that accepts the character, and the output register is then loaded from it.
// One character per cycle while each causes at most one result and out_stall
// is low; a character's several results leave one at a time through the single
// output register. A two-entry bundle queue decouples front and back.
//
// in_stall is high while the queue is full. When the receiver stalls, the
// output holds and the queue fills, then the input stalls.
// Reset clears tokenizer state, the queue and the output valid.
`timescale 1ns / 1ps
module script_tokenizer_with_comments import stok_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic               end_of_script,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  kind,
	output logic [CHAR_W-1:0]  token_char,
	output logic               last_in_run
);

	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_not_empty;
	bundle_t push_data;
	bundle_t head;

	stok_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.char_code    (char_code),
		.end_of_script(end_of_script),
		.q_full       (q_full),
		.in_stall     (in_stall),
		.push         (push),
		.push_data    (push_data)
	);

	stok_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	stok_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (q_not_empty),
		.head       (head),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.kind       (kind),
		.token_char (token_char),
		.last_in_run(last_in_run)
	);

endmodule
